// ----- design/lkvt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lkvt_pkg;

  // fixed field widths of the stream words
  localparam int OP_W        = 2;
  localparam int KEY_FIELD_W = 32;
  localparam int VAL_FIELD_W = 32;
  localparam int OCC_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // parameter defaults
  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- design/linear_key_value_table_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// key-value table of CAPACITY entries, kept packed in insertion order in two
// one-port-read synchronous memories (keys and values, registered read).
// each input word carries an operation in in_tuser: insert/update, lookup,
// remove or clear; each yields exactly one result word with found flag, looked
// up value, status (ok, key missing, table full), entry count and empty flag.
// a word is taken only while the sequencer is idle; the result sits in an
// output register, so the next word is accepted while it still waits.
// per word: clear skips the scan; insert, lookup and remove scan from position 0,
// comparing one stored key per cycle, until a hit or the last entry (on an
// empty table nothing matches). a remove that hits before the last entry then
// shifts the later entries down, one entry moved per cycle. a finished result
// waits while the output register is still full and out_tready is low.
// the memories hold no reset; only entries below the count are ever used.

module linear_key_value_table_top #(
  parameter int CAPACITY   = lkvt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = lkvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lkvt_pkg::IN_TDATA_W-1:0]    in_tdata,   // search_key, new_value
  input  wire logic [lkvt_pkg::OP_W-1:0]          in_tuser,   // op
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [lkvt_pkg::OUT_TDATA_W-1:0]        out_tdata,  // found, read_value,
                                                              // occupancy, is_empty, pad
  output logic [lkvt_pkg::STATUS_W-1:0]           out_tuser   // status
);

  import lkvt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // bits of the 32-bit fields that are actually kept
  localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int VW = (VALUE_BITS < VAL_FIELD_W) ? VALUE_BITS : VAL_FIELD_W;

  // storage: keys and values, read address registered inside the memory
  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  key_we;
  logic                  val_we;
  logic [KEY_BITS-1:0]   key_wd;
  logic [VALUE_BITS-1:0] val_wd;

  // sequencer state
  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;     // index of the entry on the read port while scanning
  logic                  found_r, found_nxt;
  logic [VALUE_BITS-1:0] rdv_r, rdv_nxt;
  status_t               status_r, status_nxt;

  // captured word
  op_t                   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // output register
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [VAL_FIELD_W-1:0] out_rdv_r;
  logic [OCC_W-1:0]      out_occ_r;
  logic                  out_empty_r;
  status_t               out_status_r;
  logic                  out_load;

  logic                  in_acc;
  logic                  hit;
  logic                  last;

  assign in_acc = in_tvalid && in_tready;

  // scan compare: the entry at idx_r is on the read port
  assign hit  = (count_r != '0) && (key_q == key_r);
  assign last = (count_r == '0) || ((CW'(idx_r) + CW'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wd;
    end
    if (val_we) begin
      val_mem[wr_addr] <= val_wd;
    end
    key_q <= key_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(in_tuser);
      key_r <= KEY_BITS'(in_tdata[KW-1:0]);
      val_r <= VALUE_BITS'(in_tdata[KEY_FIELD_W +: VW]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    rdv_r    <= rdv_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    rdv_nxt    = rdv_r;
    status_nxt = status_r;
    in_tready  = 1'b0;
    out_load   = 1'b0;
    rd_addr    = idx_r + AW'(1);
    wr_addr    = idx_r;
    key_we     = 1'b0;
    val_we     = 1'b0;
    key_wd     = key_r;
    val_wd     = val_r;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          idx_nxt    = '0;
          rd_addr    = '0;
          found_nxt  = 1'b0;
          rdv_nxt    = '0;
          status_nxt = ST_OK;
          if (op_t'(in_tuser) == OP_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          state_nxt = S_FINISH;
          case (op_r)
            OP_INSERT: begin
              // update in place
              val_we = 1'b1;
            end
            OP_LOOKUP: begin
              rdv_nxt = val_q;
            end
            OP_REMOVE: begin
              if (last) begin
                count_nxt = count_r - CW'(1);
              end else begin
                // read one ahead, write one behind
                rd_addr   = idx_r + AW'(1);
                state_nxt = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end else if (last) begin
          state_nxt = S_FINISH;
          if (op_r == OP_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              // append at the end
              key_we    = 1'b1;
              val_we    = 1'b1;
              wr_addr   = AW'(count_r);
              count_nxt = count_r + CW'(1);
            end
          end else begin
            status_nxt = ST_MISSING;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_r + AW'(1);
        end
      end

      S_SHIFT: begin
        // entry idx_r + 1 is on the read port, move it down to idx_r
        key_we  = 1'b1;
        val_we  = 1'b1;
        wr_addr = idx_r;
        key_wd  = key_q;
        val_wd  = val_q;
        if ((CW'(idx_r) + CW'(2)) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_r + AW'(2);
        end
      end

      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r  <= found_r;
      out_rdv_r    <= VAL_FIELD_W'(rdv_r);
      out_status_r <= status_r;
      out_occ_r    <= OCC_W'(count_r);
      out_empty_r  <= (count_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_empty_r, out_occ_r, out_rdv_r, out_found_r};
  assign out_tuser  = out_status_r;

  // entry count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // a clear empties the table on the next cycle
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op_t'(in_tuser) == OP_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the table");

  // writes only land inside the packed list or just at its end
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (key_we || val_we) |-> (CW'(wr_addr) <= count_r))
    else $error("write outside the live entries");

  // a found key never comes with an error status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(found_r && (status_r != ST_OK)))
    else $error("found key reported with error status");

endmodule

`default_nettype wire
